/* rtl/core/pitc_pkg.sv */
// ----------------------------------------------------------------------------
// pitc_pkg
// Shared types, constants and reset values for the timestamp frequency
// calibrator: configuration record, phase and controller state codes, and
// the command and status records between controller and datapath.
// ----------------------------------------------------------------------------
package pitc_pkg;

    // Stamp arithmetic width
    localparam int STAMP_W_DEF = 64;

    // Divisor is step * 256000, step up to 255: 26 bits
    localparam int DIV_W = 26;
    localparam logic [17:0] STEP_SCALE = 18'd256000;

    localparam logic [7:0]  BYTE_FIRST  = 8'hFF;
    localparam logic [7:0]  BYTE_SECOND = 8'hFE;
    localparam logic [15:0] MIN_MATCHES = 16'd6;
    localparam int          ERR_SHIFT   = 11;

    // Configuration reset values
    localparam logic [23:0] REF_HZ_RST       = 24'd1193182;
    localparam logic [7:0]  MAX_STEPS_RST    = 8'd116;
    localparam logic [15:0] READ_LIMIT_RST   = 16'd50000;
    localparam logic [6:0]  MAX_ATTEMPTS_RST = 7'd99;
    localparam logic [31:0] DEFAULT_KHZ_RST  = 32'd2500000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_HZ,
        CFG_MAX_STEPS,
        CFG_READ_LIMIT,
        CFG_MAX_ATTEMPTS,
        CFG_DEFAULT_KHZ
    } cfg_index_t;

    typedef struct packed {
        logic [23:0] ref_hz;
        logic [7:0]  max_steps;
        logic [15:0] read_limit;
        logic [6:0]  max_attempts;
        logic [31:0] default_khz;
    } cfg_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRIME,
        PH_RUN,
        PH_VERIFY,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_FAILED     = 2'd0,
        ST_CALIBRATED = 2'd1,
        ST_DEFAULT    = 2'd2
    } out_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLOSE,
        S_CHECK,
        S_FAIL,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV_START,
        S_DIV_WAIT,
        S_DIV_END,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_START,
        OP_BEGIN_RUN,
        OP_SAMPLE,
        OP_CLOSE_FIRST,
        OP_CLOSE_LATER,
        OP_ADVANCE,
        OP_VERIFY,
        OP_FAIL,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV_START,
        OP_LOAD_QUOT,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        out_status_t emit_status;
    } dp_cmd_t;

    typedef struct packed {
        logic start_req;
        logic msb_match;
        logic sample_closes;
        logic run_ok;
        logic step_zero;
        logic max_steps_zero;
        logic err_ge;
        logic step_ge_max;
        logic fail_to_default;
        logic max_attempts_zero;
        logic div_done;
        logic quot_zero;
    } dp_status_t;

endpackage

/* rtl/core/pitc_divider.sv */
// ----------------------------------------------------------------------------
// pitc_divider
// Restoring divider, one quotient bit per cycle. Pulses done for one cycle
// when the quotient is ready; the quotient holds until the next start.
// ----------------------------------------------------------------------------
module pitc_divider #(
    parameter int DIVIDEND_W = 64,
    parameter int DIVISOR_W  = 26
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial     = rem_shift - {1'b0, divisor_reg};
    assign fits      = !trial[DIVISOR_W];

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/pitc_datapath.sv */
// ----------------------------------------------------------------------------
// pitc_datapath
// Sample registers, run tracking, gap and error checks, the frequency
// arithmetic (correction, split multiply, serial divide) and the result
// word register. Acts on one command per cycle from the controller.
// ----------------------------------------------------------------------------
module pitc_datapath #(
    parameter int STAMP_W = pitc_pkg::STAMP_W_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pitc_pkg::cfg_t      cfg,
    input  pitc_pkg::dp_cmd_t   cmd,
    output pitc_pkg::dp_status_t stat,
    input  logic                mode,
    input  logic [7:0]          counter_msb,
    input  logic [63:0]         timestamp,
    output logic [1:0]          status,
    output logic [63:0]         freq_hz
);

    import pitc_pkg::*;

    // Architectural state
    logic [7:0]         expected_reg, expected_next;
    logic [15:0]        match_reg, match_next;
    logic [STAMP_W-1:0] run_last_reg, run_last_next;
    logic [STAMP_W-1:0] base_reg, base_next;
    logic [STAMP_W-1:0] first_gap_reg, first_gap_next;
    logic [STAMP_W-1:0] latest_gap_reg, latest_gap_next;
    logic [7:0]         step_reg, step_next;
    logic [6:0]         attempt_reg, attempt_next;
    logic [STAMP_W-1:0] result_khz_reg, result_khz_next;

    // Working registers
    logic               in_mode_reg;
    logic [7:0]         in_msb_reg;
    logic [STAMP_W-1:0] in_ts_reg;
    logic [STAMP_W-1:0] gap_reg;
    logic [STAMP_W-1:0] elapsed_reg;
    logic [STAMP_W-1:0] diff_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [DIV_W-1:0]   divisor_reg;
    logic [1:0]         out_status_reg;
    logic [63:0]        out_freq_reg;

    logic [15:0]        match_inc;
    logic [15:0]        limit_eff;
    logic [6:0]         attempt_inc;
    logic [STAMP_W-1:0] err_sum;
    logic [STAMP_W-1:0] corrected;
    logic [DIV_W-1:0]   step_scaled;
    logic [63:0]        elapsed64;
    logic [31:0]        mul_a;
    logic [55:0]        mul_p;
    logic [63:0]        khz64;
    logic [63:0]        khz_x1000;
    logic [STAMP_W-1:0] quotient;
    logic               div_done;
    logic               msb_match;

    assign match_inc   = match_reg + 16'd1;
    assign limit_eff   = (cfg.read_limit == '0) ? 16'd1 : cfg.read_limit;
    assign attempt_inc = attempt_reg + 7'd1;
    assign msb_match   = (in_msb_reg == expected_reg);
    assign err_sum     = first_gap_reg + latest_gap_reg;
    assign corrected   = neg_reg ? (elapsed_reg - (diff_reg >> 1))
                                 : (elapsed_reg + (diff_reg >> 1));
    assign step_scaled = DIV_W'(step_reg) * DIV_W'(STEP_SCALE);

    // One 32 x 24 multiplier, used for the low then the high half
    assign elapsed64 = 64'(elapsed_reg);
    assign mul_a     = (cmd.op == OP_MUL_HI) ? elapsed64[63:32] : elapsed64[31:0];
    assign mul_p     = 56'(mul_a) * 56'(cfg.ref_hz);

    // kHz to Hz: 1024 - 16 - 8 = 1000
    assign khz64     = 64'(result_khz_reg);
    assign khz_x1000 = (khz64 << 10) - (khz64 << 4) - (khz64 << 3);

    pitc_divider #(
        .DIVIDEND_W (STAMP_W),
        .DIVISOR_W  (DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV_START),
        .dividend (prod_reg[STAMP_W-1:0]),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        stat.start_req         = !in_mode_reg;
        stat.msb_match         = msb_match;
        stat.sample_closes     = !msb_match || (match_inc >= limit_eff);
        stat.run_ok            = (match_reg >= MIN_MATCHES);
        stat.step_zero         = (step_reg == '0);
        stat.max_steps_zero    = (cfg.max_steps == '0);
        stat.err_ge            = (err_sum >= (elapsed_reg >> ERR_SHIFT));
        stat.step_ge_max       = (step_reg >= cfg.max_steps);
        stat.fail_to_default   = (attempt_inc >= cfg.max_attempts);
        stat.max_attempts_zero = (cfg.max_attempts == '0);
        stat.div_done          = div_done;
        stat.quot_zero         = (quotient == '0);
    end

    always_comb
    begin
        expected_next   = expected_reg;
        match_next      = match_reg;
        run_last_next   = run_last_reg;
        base_next       = base_reg;
        first_gap_next  = first_gap_reg;
        latest_gap_next = latest_gap_reg;
        step_next       = step_reg;
        attempt_next    = attempt_reg;
        result_khz_next = result_khz_reg;
        unique case (cmd.op)
            OP_START:
            begin
                attempt_next = '0;
                if (cfg.max_attempts == '0)
                begin
                    result_khz_next = STAMP_W'(cfg.default_khz);
                end
                else
                begin
                    result_khz_next = '0;
                    step_next       = '0;
                    match_next      = '0;
                    run_last_next   = '0;
                    expected_next   = BYTE_FIRST;
                end
            end
            OP_BEGIN_RUN:
            begin
                expected_next = BYTE_FIRST;
                match_next    = '0;
                run_last_next = '0;
            end
            OP_SAMPLE:
            begin
                if (msb_match)
                begin
                    match_next    = match_inc;
                    run_last_next = in_ts_reg;
                end
            end
            OP_CLOSE_FIRST:
            begin
                base_next      = run_last_reg;
                first_gap_next = gap_reg;
                step_next      = 8'd1;
                expected_next  = BYTE_SECOND;
                match_next     = '0;
                run_last_next  = '0;
            end
            OP_CLOSE_LATER:
            begin
                latest_gap_next = gap_reg;
            end
            OP_ADVANCE:
            begin
                step_next     = step_reg + 8'd1;
                expected_next = BYTE_SECOND - step_reg;
                match_next    = '0;
                run_last_next = '0;
            end
            OP_VERIFY:
            begin
                expected_next = BYTE_SECOND - step_reg;
            end
            OP_FAIL:
            begin
                attempt_next = attempt_inc;
                if (attempt_inc >= cfg.max_attempts)
                begin
                    result_khz_next = STAMP_W'(cfg.default_khz);
                end
                else
                begin
                    step_next     = '0;
                    match_next    = '0;
                    run_last_next = '0;
                    expected_next = BYTE_FIRST;
                end
            end
            OP_LOAD_QUOT:
            begin
                result_khz_next = quotient;
            end
            OP_NONE, OP_LATCH, OP_FIN1, OP_FIN2, OP_FIN3, OP_MUL_LO, OP_MUL_HI,
            OP_DIV_START, OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg   <= BYTE_FIRST;
            match_reg      <= '0;
            run_last_reg   <= '0;
            base_reg       <= '0;
            first_gap_reg  <= '0;
            latest_gap_reg <= '0;
            step_reg       <= '0;
            attempt_reg    <= '0;
            result_khz_reg <= '0;
        end
        else
        begin
            expected_reg   <= expected_next;
            match_reg      <= match_next;
            run_last_reg   <= run_last_next;
            base_reg       <= base_next;
            first_gap_reg  <= first_gap_next;
            latest_gap_reg <= latest_gap_next;
            step_reg       <= step_next;
            attempt_reg    <= attempt_next;
            result_khz_reg <= result_khz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                in_mode_reg <= mode;
                in_msb_reg  <= counter_msb;
                in_ts_reg   <= timestamp[STAMP_W-1:0];
            end
            OP_SAMPLE:
            begin
                gap_reg <= msb_match ? '0 : (in_ts_reg - run_last_reg);
            end
            OP_CLOSE_LATER:
            begin
                elapsed_reg <= run_last_reg - base_reg;
            end
            OP_FIN1:
            begin
                diff_reg    <= latest_gap_reg - first_gap_reg;
                elapsed_reg <= run_last_reg - base_reg;
                divisor_reg <= step_scaled;
            end
            OP_FIN2:
            begin
                // split the signed gap difference into sign and magnitude
                neg_reg  <= diff_reg[STAMP_W-1];
                diff_reg <= diff_reg[STAMP_W-1] ? (STAMP_W'(0) - diff_reg) : diff_reg;
            end
            OP_FIN3:
            begin
                elapsed_reg <= corrected;
            end
            OP_MUL_LO:
            begin
                prod_reg <= 64'(mul_p);
            end
            OP_MUL_HI:
            begin
                prod_reg <= prod_reg + {mul_p[31:0], 32'd0};
            end
            OP_EMIT:
            begin
                out_status_reg <= cmd.emit_status;
                out_freq_reg   <= (cmd.emit_status == ST_FAILED) ? 64'd0 : khz_x1000;
            end
            OP_NONE, OP_START, OP_BEGIN_RUN, OP_CLOSE_FIRST, OP_ADVANCE, OP_VERIFY,
            OP_FAIL, OP_DIV_START, OP_LOAD_QUOT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign status  = out_status_reg;
    assign freq_hz = out_freq_reg;

endmodule

/* rtl/core/pitc_ctrl.sv */
// ----------------------------------------------------------------------------
// pitc_ctrl
// Controller: tracks the calibration phase, sequences each sample through
// decode, run close and error check, drives the finish arithmetic and the
// serial divide, and hands result words to the output register.
// ----------------------------------------------------------------------------
module pitc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pitc_pkg::dp_cmd_t    cmd,
    input  pitc_pkg::dp_status_t stat
);

    import pitc_pkg::*;

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    out_status_t emit_status_reg, emit_status_next;
    logic        out_valid_reg, out_valid_next;
    dp_op_t      op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_IDLE;
            emit_status_reg <= ST_FAILED;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            emit_status_reg <= emit_status_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        emit_status_next = emit_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        op               = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.start_req)
                begin
                    op = OP_START;
                    if (stat.max_attempts_zero)
                    begin
                        phase_next       = PH_DONE;
                        emit_status_next = ST_DEFAULT;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        phase_next = PH_PRIME;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_PRIME:
                        begin
                            // drop the priming sample
                            op         = OP_BEGIN_RUN;
                            phase_next = PH_RUN;
                            state_next = S_IDLE;
                        end
                        PH_RUN:
                        begin
                            op         = OP_SAMPLE;
                            state_next = stat.sample_closes ? S_CLOSE : S_IDLE;
                        end
                        PH_VERIFY:
                        begin
                            state_next = stat.msb_match ? S_FIN1 : S_FAIL;
                        end
                        PH_IDLE, PH_DONE:
                        begin
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLOSE:
            begin
                if (!stat.run_ok)
                begin
                    state_next = S_FAIL;
                end
                else if (stat.step_zero)
                begin
                    op         = OP_CLOSE_FIRST;
                    state_next = stat.max_steps_zero ? S_FAIL : S_IDLE;
                end
                else
                begin
                    op         = OP_CLOSE_LATER;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.err_ge)
                begin
                    if (stat.step_ge_max)
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        op         = OP_ADVANCE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // error small enough: wait for the confirming byte
                    op         = OP_VERIFY;
                    phase_next = PH_VERIFY;
                    state_next = S_IDLE;
                end
            end
            S_FAIL:
            begin
                op = OP_FAIL;
                if (stat.fail_to_default)
                begin
                    phase_next       = PH_DONE;
                    emit_status_next = ST_DEFAULT;
                end
                else
                begin
                    phase_next       = PH_PRIME;
                    emit_status_next = ST_FAILED;
                end
                state_next = S_EMIT;
            end
            S_FIN1:
            begin
                op         = OP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                op         = OP_FIN2;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                op         = OP_FIN3;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                op         = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                op         = OP_MUL_HI;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                op         = OP_DIV_START;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                if (stat.quot_zero)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    op               = OP_LOAD_QUOT;
                    phase_next       = PH_DONE;
                    emit_status_next = ST_CALIBRATED;
                    state_next       = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign cmd.op          = op;
    assign cmd.emit_status = emit_status_reg;

endmodule

/* rtl/core/pit_tsc_freq_calibrator_top.sv */
// ----------------------------------------------------------------------------
// A sample or start word is accepted in S_IDLE and decoded in S_DECODE; one
// that closes a run also passes S_CLOSE, and S_CHECK for the error check. A
// result word adds S_EMIT, a failed attempt also S_FAIL; a confirming sample
// runs the finish steps, the split multiply and the serial divide (one quotient
// bit per cycle). A held result word stalls input once the next is due.
// Reset (rst_n, async) idles the block and loads the config defaults.
// ----------------------------------------------------------------------------
// pit_tsc_freq_calibrator_top
// Measures a free running timestamp rate against the high byte of a
// reference down-counter. Holds the configuration registers and joins the
// controller with the datapath.
// ----------------------------------------------------------------------------
module pit_tsc_freq_calibrator_top #(
    parameter int STAMP_WIDTH = pitc_pkg::STAMP_W_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [7:0]                      counter_msb,
    input  logic [63:0]                     timestamp,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [63:0]                     freq_hz,
    input  logic                            cfg_we,
    input  logic [pitc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pitc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import pitc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    dp_cmd_t    cmd;
    dp_status_t stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REF_HZ:       cfg_next.ref_hz       = cfg_data[23:0];
                CFG_MAX_STEPS:    cfg_next.max_steps    = cfg_data[7:0];
                CFG_READ_LIMIT:   cfg_next.read_limit   = cfg_data[15:0];
                CFG_MAX_ATTEMPTS: cfg_next.max_attempts = cfg_data[6:0];
                CFG_DEFAULT_KHZ:  cfg_next.default_khz  = cfg_data[31:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_hz       <= REF_HZ_RST;
            cfg_reg.max_steps    <= MAX_STEPS_RST;
            cfg_reg.read_limit   <= READ_LIMIT_RST;
            cfg_reg.max_attempts <= MAX_ATTEMPTS_RST;
            cfg_reg.default_khz  <= DEFAULT_KHZ_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pitc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pitc_datapath #(
        .STAMP_W (STAMP_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .counter_msb (counter_msb),
        .timestamp   (timestamp),
        .status      (status),
        .freq_hz     (freq_hz)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top: timestamp frequency calibrator testbench
// Drives sample and start words into pit_tsc_freq_calibrator_top over a
// valid/ready channel and predicts every status/frequency word in a local
// copy of the calibration state. It covers directed edge cases, zero and
// extreme register settings, a step walk closed by the read limit, output
// backpressure and random calibration sequences with random gaps on both sides.
// ============================================================================
module tb_top;
    import pitc_pkg::*;

    localparam logic        MODE_START   = 1'b0;
    localparam logic        MODE_SAMPLE  = 1'b1;
    localparam logic [7:0]  RUN_BYTE_TOP    = 8'hFF;
    localparam logic [7:0]  VERIFY_BYTE_TOP = 8'hFE;
    localparam logic [15:0] MATCHES_NEEDED  = 16'd6;
    localparam int          GAP_ERR_SHIFT   = 11;
    localparam logic [63:0] STEP_HZ_DIV     = 64'd256000;
    localparam logic [63:0] KHZ_TO_HZ       = 64'd1000;

    localparam logic [23:0] REF_HZ_DEFAULT       = 24'd1193182;
    localparam logic [7:0]  MAX_STEPS_DEFAULT    = 8'd116;
    localparam logic [15:0] READ_LIMIT_DEFAULT   = 16'd50000;
    localparam logic [6:0]  MAX_ATTEMPTS_DEFAULT = 7'd99;
    localparam logic [31:0] DEFAULT_KHZ_DEFAULT  = 32'd2500000;

    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 240;
    localparam int STEP_WALK    = 16;

    typedef struct {
        out_status_t status;
        logic [63:0] freq_hz;
    } freq_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [7:0]  counter_msb;
    logic [63:0] timestamp;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [63:0] freq_hz;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    logic [31:0] cfg_data;

    // register mirror
    logic [23:0] ref_hz_r       = REF_HZ_DEFAULT;
    logic [7:0]  max_steps_r    = MAX_STEPS_DEFAULT;
    logic [15:0] read_limit_r   = READ_LIMIT_DEFAULT;
    logic [6:0]  max_attempts_r = MAX_ATTEMPTS_DEFAULT;
    logic [31:0] default_khz_r  = DEFAULT_KHZ_DEFAULT;

    // calibration state
    phase_t      cal_phase   = PH_IDLE;
    logic [7:0]  want_byte   = 8'hFF;
    logic [15:0] run_hits    = '0;
    logic [63:0] run_end_ts  = '0;
    logic [63:0] base_ts     = '0;
    logic [63:0] gap_first   = '0;
    logic [63:0] gap_latest  = '0;
    logic [7:0]  step_no     = '0;
    logic [6:0]  fail_count  = '0;
    logic [63:0] khz_latched = '0;

    freq_word_t  pending_results[$];
    int unsigned active_items   = 0;
    int unsigned error_count    = 0;
    int unsigned rx_hold_cycles = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;

    pit_tsc_freq_calibrator_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .counter_msb (counter_msb),
        .timestamp   (timestamp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .freq_hz     (freq_hz),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void push_result(out_status_t st, logic [63:0] hz);
        freq_word_t w;
        w.status  = st;
        w.freq_hz = hz;
        pending_results.push_back(w);
    endfunction

    function automatic void start_attempt();
        step_no    = '0;
        run_hits   = '0;
        run_end_ts = '0;
        want_byte  = RUN_BYTE_TOP;
        cal_phase  = PH_PRIME;
    endfunction

    function automatic void open_run(logic [7:0] b);
        want_byte  = b;
        run_hits   = '0;
        run_end_ts = '0;
        cal_phase  = PH_RUN;
    endfunction

    function automatic void fail_attempt();
        fail_count = fail_count + 7'd1;
        if (fail_count >= max_attempts_r)
        begin
            khz_latched = {32'd0, default_khz_r};
            cal_phase   = PH_DONE;
            push_result(ST_DEFAULT, khz_latched * KHZ_TO_HZ);
        end
        else
        begin
            start_attempt();
            push_result(ST_FAILED, 64'd0);
        end
    endfunction

    function automatic void close_run(logic [63:0] gap);
        logic [63:0] elapsed;
        if (run_hits < MATCHES_NEEDED)
            fail_attempt();
        else if (step_no == 8'd0)
        begin
            base_ts   = run_end_ts;
            gap_first = gap;
            if (max_steps_r == 8'd0)
                fail_attempt();
            else
            begin
                step_no = 8'd1;
                open_run(8'(RUN_BYTE_TOP - step_no));
            end
        end
        else
        begin
            gap_latest = gap;
            elapsed    = run_end_ts - base_ts;
            if (64'(gap_first + gap_latest) >= (elapsed >> GAP_ERR_SHIFT))
            begin
                if (step_no >= max_steps_r)
                    fail_attempt();
                else
                begin
                    step_no = step_no + 8'd1;
                    open_run(8'(RUN_BYTE_TOP - step_no));
                end
            end
            else
            begin
                want_byte = 8'(VERIFY_BYTE_TOP - step_no);
                cal_phase = PH_VERIFY;
            end
        end
    endfunction

    // Advance the calibration by one accepted word and queue any result word.
    function automatic void track_calibration(logic m, logic [7:0] b, logic [63:0] ts);
        logic [15:0] limit;
        logic [63:0] elapsed;
        logic [63:0] diff;
        logic [63:0] khz;
        limit = (read_limit_r == 16'd0) ? 16'd1 : read_limit_r;
        if (m == MODE_START)
        begin
            fail_count  = '0;
            khz_latched = '0;
            if (max_attempts_r == 7'd0)
            begin
                khz_latched = {32'd0, default_khz_r};
                cal_phase   = PH_DONE;
                push_result(ST_DEFAULT, khz_latched * KHZ_TO_HZ);
            end
            else
                start_attempt();
        end
        else
        begin
            case (cal_phase)
                PH_PRIME:
                    open_run(RUN_BYTE_TOP);
                PH_RUN:
                    if (b == want_byte)
                    begin
                        run_hits   = run_hits + 16'd1;
                        run_end_ts = ts;
                        if (run_hits >= limit)
                            close_run(64'd0);
                    end
                    else
                        close_run(ts - run_end_ts);
                PH_VERIFY:
                    if (b == want_byte)
                    begin
                        // half the gap difference, rounded toward zero
                        elapsed = run_end_ts - base_ts;
                        diff    = gap_latest - gap_first;
                        if (diff[63])
                            elapsed = elapsed - ((-diff) >> 1);
                        else
                            elapsed = elapsed + (diff >> 1);
                        elapsed = elapsed * {40'd0, ref_hz_r};
                        khz     = elapsed / ({56'd0, step_no} * STEP_HZ_DIV);
                        if (khz == 64'd0)
                            fail_attempt();
                        else
                        begin
                            khz_latched = khz;
                            cal_phase   = PH_DONE;
                            push_result(ST_CALIBRATED, khz * KHZ_TO_HZ);
                        end
                    end
                    else
                        fail_attempt();
                default:
                    ;
            endcase
        end
    endfunction

    task automatic send_word(logic m, logic [7:0] b, logic [63:0] ts);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        counter_msb <= b;
        timestamp   <= ts;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (m == MODE_START || (cal_phase != PH_IDLE && cal_phase != PH_DONE))
            active_items++;
        track_calibration(m, b, ts);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_REF_HZ:       ref_hz_r       = value[23:0];
            CFG_MAX_STEPS:    max_steps_r    = value[7:0];
            CFG_READ_LIMIT:   read_limit_r   = value[15:0];
            CFG_MAX_ATTEMPTS: max_attempts_r = value[6:0];
            CFG_DEFAULT_KHZ:  default_khz_r  = value;
            default:          ;
        endcase
    endtask

    // Drop valid, wait for every result word, then let the pipeline run dry.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One calibration attempt: start, priming word, n_steps+1 byte runs, then
    // the confirming word. The last run sits at least 2^jump_bits ticks later so that
    // its error check passes; wide closing gaps keep earlier steps failing it.
    task automatic send_calibration(int n_steps, int jump_bits, bit allow_fault);
        logic [63:0] t;
        logic [7:0]  run_byte;
        int          fault;
        int          bad_step;
        int          hits;
        int          s;
        int          k;
        fault    = allow_fault ? $urandom_range(0, 9) : 0;
        bad_step = $urandom_range(0, n_steps);
        t        = {$urandom, $urandom};
        send_word(MODE_START, 8'($urandom), {$urandom, $urandom});
        send_word(MODE_SAMPLE, 8'($urandom), {$urandom, $urandom});
        for (s = 0; s <= n_steps; s++)
        begin
            run_byte = 8'(RUN_BYTE_TOP - s);
            hits = (fault == 6 && s == bad_step) ? $urandom_range(1, 5) : $urandom_range(6, 9);
            if (s == n_steps)
                t += (64'd1 << jump_bits) + ({$urandom, $urandom} >> (64 - jump_bits));
            for (k = 0; k < hits; k++)
            begin
                t += $urandom_range(1, 8);
                if (fault == 8 && s == bad_step && k == 2)
                    send_word(MODE_SAMPLE, 8'($urandom), {$urandom, $urandom});
                send_word(MODE_SAMPLE, run_byte, t);
            end
            t += (s == 0 || s == n_steps) ? $urandom_range(0, 15) : $urandom_range(600, 4000);
            send_word(MODE_SAMPLE, 8'(run_byte - 8'd1), t);
        end
        if (fault == 9)
            return;
        t += $urandom_range(1, 50);
        send_word(MODE_SAMPLE,
                  (fault == 7) ? 8'($urandom) : 8'(VERIFY_BYTE_TOP - n_steps), t);
    endtask

    task automatic test_directed_default();
        logic [63:0] t;
        int          k;
        // ignored while idle
        send_word(MODE_SAMPLE, 8'h00, 64'd0);
        send_word(MODE_START, 8'hFF, '1);
        send_word(MODE_SAMPLE, 8'hA5, 64'd0);
        t = 64'hFFFF_FFFF_FFF0_0000;
        for (k = 0; k < 6; k++)
        begin
            t += 64'd3;
            send_word(MODE_SAMPLE, 8'hFF, t);
        end
        t += 64'd7;
        send_word(MODE_SAMPLE, 8'hFE, t);
        // wrap the stamp past zero; the later gap is shorter than the first
        t += 64'd1 << 24;
        for (k = 0; k < 6; k++)
        begin
            t += 64'd2;
            send_word(MODE_SAMPLE, 8'hFE, t);
        end
        t += 64'd4;
        send_word(MODE_SAMPLE, 8'hFD, t);
        send_word(MODE_SAMPLE, 8'hFD, t + 64'd10);
        // ignored once done
        send_word(MODE_SAMPLE, 8'h80, {$urandom, $urandom});
        settle();
    endtask

    task automatic test_zero_settings();
        write_reg(CFG_DEFAULT_KHZ, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_ATTEMPTS, 32'd0);
        send_word(MODE_START, 8'h3C, {$urandom, $urandom});
        send_word(MODE_SAMPLE, 8'hFF, {$urandom, $urandom});
        settle();
        write_reg(CFG_MAX_ATTEMPTS, 32'd2);
        write_reg(CFG_MAX_STEPS, 32'd0);
        send_calibration(1, 30, 1'b0);
        settle();
        write_reg(CFG_MAX_STEPS, {24'd0, MAX_STEPS_DEFAULT});
        write_reg(CFG_READ_LIMIT, 32'd0);
        send_calibration(1, 30, 1'b0);
        settle();
        write_reg(CFG_READ_LIMIT, {16'd0, READ_LIMIT_DEFAULT});
        write_reg(CFG_MAX_ATTEMPTS, {25'd0, MAX_ATTEMPTS_DEFAULT});
        write_reg(CFG_DEFAULT_KHZ, DEFAULT_KHZ_DEFAULT);
    endtask

    task automatic test_zero_quotient();
        write_reg(CFG_REF_HZ, 32'd1);
        send_calibration(2, 17, 1'b0);
        settle();
    endtask

    task automatic test_product_overflow();
        write_reg(CFG_REF_HZ, 32'h00FF_FFFF);
        send_calibration(1, 60, 1'b0);
        send_calibration(3, 58, 1'b0);
        settle();
        write_reg(CFG_REF_HZ, {8'd0, REF_HZ_DEFAULT});
    endtask

    task automatic test_attempt_exhaustion();
        write_reg(CFG_MAX_ATTEMPTS, 32'd3);
        write_reg(CFG_MAX_STEPS, 32'd1);
        send_calibration(3, 40, 1'b0);
        send_calibration(3, 40, 1'b0);
        settle();
        write_reg(CFG_MAX_ATTEMPTS, 32'd127);
        write_reg(CFG_MAX_STEPS, {24'd0, MAX_STEPS_DEFAULT});
    endtask

    // Walk STEP_WALK byte runs, each closed by the read limit with a zero gap;
    // the last run sits far out so that its error check passes.
    task automatic test_read_limit_steps();
        logic [63:0] t;
        int          s;
        write_reg(CFG_READ_LIMIT, 32'd6);
        write_reg(CFG_MAX_STEPS, 32'd255);
        t = {$urandom, $urandom};
        send_word(MODE_START, 8'h00, 64'd0);
        send_word(MODE_SAMPLE, 8'h5A, t);
        for (s = 0; s < STEP_WALK; s++)
        begin
            if (s == STEP_WALK - 1)
                t += 64'd1 << 24;
            repeat (MATCHES_NEEDED)
            begin
                t += 64'd1;
                send_word(MODE_SAMPLE, 8'(RUN_BYTE_TOP - s), t);
            end
        end
        send_word(MODE_SAMPLE, 8'(VERIFY_BYTE_TOP - (STEP_WALK - 1)), t + 64'd1);
        settle();
        write_reg(CFG_READ_LIMIT, 32'h0000_FFFF);
        write_reg(CFG_MAX_STEPS, {24'd0, MAX_STEPS_DEFAULT});
    endtask

    // Every start emits a word at once; hold the output so the block backs up.
    task automatic test_backpressure();
        write_reg(CFG_MAX_ATTEMPTS, 32'd0);
        write_reg(CFG_DEFAULT_KHZ, $urandom_range(1, 32'hFFFF_FFFF));
        tx_idle        = 1'b0;
        rx_hold_cycles = 400;
        repeat (24) send_word(MODE_START, 8'($urandom), {$urandom, $urandom});
        tx_idle = 1'b1;
        settle();
        write_reg(CFG_MAX_ATTEMPTS, {25'd0, MAX_ATTEMPTS_DEFAULT});
        write_reg(CFG_DEFAULT_KHZ, DEFAULT_KHZ_DEFAULT);
    endtask

    task automatic test_random_calibrations();
        int unsigned first_item;
        int          round;
        first_item = active_items;
        round      = 0;
        while (active_items - first_item < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       write_reg(CFG_REF_HZ, 32'd1);
                1:       write_reg(CFG_REF_HZ, 32'h00FF_FFFF);
                default: write_reg(CFG_REF_HZ, $urandom_range(1, 32'h00FF_FFFF));
            endcase
            write_reg(CFG_MAX_STEPS,
                      ($urandom_range(0, 3) == 0) ? 32'd255 : $urandom_range(1, 6));
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_READ_LIMIT, $urandom_range(6, 12));
                1:       write_reg(CFG_READ_LIMIT, 32'h0000_FFFF);
                default: write_reg(CFG_READ_LIMIT, $urandom_range(13, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_MAX_ATTEMPTS, 32'd1);
                1:       write_reg(CFG_MAX_ATTEMPTS, 32'd127);
                default: write_reg(CFG_MAX_ATTEMPTS, $urandom_range(2, 5));
            endcase
            case ($urandom_range(0, 2))
                0:       write_reg(CFG_DEFAULT_KHZ, 32'd1);
                1:       write_reg(CFG_DEFAULT_KHZ, 32'hFFFF_FFFF);
                default: write_reg(CFG_DEFAULT_KHZ, $urandom);
            endcase
            // every third round runs back to back on the input, every fourth
            // on the output
            tx_idle = (round % 3 != 2);
            rx_idle = (round % 4 != 3);
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(0, 7) == 0)
                    send_word(1'($urandom), 8'($urandom), {$urandom, $urandom});
                else
                    send_calibration($urandom_range(1, 5), $urandom_range(17, 60), 1'b1);
            end
            settle();
            round++;
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // result sink and checker
    initial
    begin : result_sink
        int unsigned stall;
        freq_word_t  want;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                stall = rx_idle ? $urandom_range(0, 17) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected: status %0d freq_hz %0d",
                       status, freq_hz);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
                if (freq_hz !== want.freq_hz)
                begin
                    $error("freq_hz: expected %0d, actual %0d", want.freq_hz, freq_hz);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= MODE_START;
        counter_msb <= 8'd0;
        timestamp   <= 64'd0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_REF_HZ;
        cfg_data    <= 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_default();
        test_zero_settings();
        test_zero_quotient();
        test_product_overflow();
        test_attempt_exhaustion();
        test_read_limit_steps();
        test_backpressure();
        test_random_calibrations();

        if (error_count == 0)
            $display("PASS pit_tsc_freq_calibrator_top");
        else
            $display("FAIL pit_tsc_freq_calibrator_top");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL pit_tsc_freq_calibrator_top");
        $finish;
    end

endmodule
